>>> design/i2ctrb_pkg.sv
// Shared types, codes, reset values and tables of the I2C target register bank.
package i2ctrb_pkg;

  localparam int DEV_SLOTS_DEF = 8;
  localparam int REG_DEPTH_DEF = 16;

  // Only eight addresses fit in the address register.
  localparam int MAX_PACKED = 8;
  localparam int DEV_W      = 3;
  localparam int ADDR_W     = 7;

  localparam logic [55:0] DEV_ADDR_RST  = 56'd4037685601480;
  localparam logic [3:0]  DEV_COUNT_RST = 4'd6;
  localparam logic [7:0]  WIDE_MASK_RST = 8'd2;

  localparam logic [1:0] CFG_DEV_ADDR  = 2'd0;
  localparam logic [1:0] CFG_DEV_COUNT = 2'd1;
  localparam logic [1:0] CFG_WIDE_MASK = 2'd2;

  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_STOP  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_READ  = 2'd3;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_NEW     = 3'd1;
  localparam logic [2:0] PH_PTR     = 3'd2;
  localparam logic [2:0] PH_RX_HALF = 3'd3;
  localparam logic [2:0] PH_RX_FULL = 3'd4;
  localparam logic [2:0] PH_TX_HALF = 3'd5;
  localparam logic [2:0] PH_TX_FULL = 3'd6;

  typedef struct packed {
    logic             found;
    logic [DEV_W-1:0] dev;
  } match_t;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_t;

  // Byte value reduced modulo depth, built by counting with wrap.
  function automatic logic [255:0][7:0] mod_table(input int depth);
    logic [255:0][7:0] tab;
    int                val;
    val = 0;
    for (int i = 0; i < 256; i++) begin
      tab[i] = 8'(val);
      if (val + 1 == depth) val = 0;
      else val = val + 1;
    end
    return tab;
  endfunction

endpackage

>>> design/i2ctrb_match.sv
// Address matcher: picks the lowest enabled device whose address equals the target.
module i2ctrb_match #(
  parameter int USED = i2ctrb_pkg::MAX_PACKED
) (
  input  logic [55:0]              dev_addr,
  input  logic [3:0]               dev_count,
  input  logic [6:0]               target,
  output i2ctrb_pkg::match_t       match
);
  import i2ctrb_pkg::*;

  always_comb begin
    match = '0;
    // Scan from the top so the lowest index wins.
    for (int i = USED - 1; i >= 0; i--) begin
      if ((dev_count > 4'(i)) && (dev_addr[ADDR_W*i +: ADDR_W] == target)) begin
        match.found = 1'b1;
        match.dev   = DEV_W'(i);
      end
    end
  end

endmodule

>>> design/i2c_target_register_bank.sv
// I2C target register bank: several emulated targets sharing one register memory.
// An accepted event and its memory read are registered, then enter the result register.
// A new event is accepted only once the previous one has left the read-modify-write.
// A full result register stalls the write-back cycle until the result is taken.
// Reset: synchronous; a clearing pass then zeroes all USED*REG_DEPTH memory entries,
// one entry per cycle (USED is DEV_SLOTS, at most 8 devices), with no input accepted meanwhile.
module i2c_target_register_bank #(
  parameter int DEV_SLOTS = i2ctrb_pkg::DEV_SLOTS_DEF,
  parameter int REG_DEPTH = i2ctrb_pkg::REG_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd[1:0], target_address[8:2], write_data[16:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // read_data[7:0], device_found[8]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [55:0] cfg_data
);
  import i2ctrb_pkg::*;

  localparam int USED   = (DEV_SLOTS < MAX_PACKED) ? DEV_SLOTS : MAX_PACKED;
  localparam int DIW    = (USED > 1) ? $clog2(USED) : 1;
  localparam int RIW    = $clog2(REG_DEPTH);
  localparam int DEPTH  = USED * REG_DEPTH;
  localparam int AW     = $clog2(DEPTH);
  localparam logic [255:0][7:0] ModTab = mod_table(REG_DEPTH);

  // configuration
  logic [55:0] dev_addr_r;
  logic [3:0]  dev_count_r;
  logic [7:0]  wide_mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= DEV_ADDR_RST;
      dev_count_r <= DEV_COUNT_RST;
      wide_mask_r <= WIDE_MASK_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:  dev_addr_r  <= cfg_data;
        CFG_DEV_COUNT: dev_count_r <= cfg_data[3:0];
        CFG_WIDE_MASK: wide_mask_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // per-device transaction state
  logic [2:0]     phase_r [USED];
  logic [RIW-1:0] index_r [USED];

  // event fields
  logic [1:0] in_cmd;
  logic [6:0] in_target;
  logic [7:0] in_wdata;
  assign in_cmd    = in_tdata[1:0];
  assign in_target = in_tdata[8:2];
  assign in_wdata  = in_tdata[16:9];

  match_t in_match;

  i2ctrb_match #(.USED(USED)) u_match (
    .dev_addr (dev_addr_r),
    .dev_count(dev_count_r),
    .target   (in_target),
    .match    (in_match)
  );

  state_t state_r, state_nxt;
  logic [AW-1:0]  clr_cnt_r;
  logic [1:0]     cmd_r;
  logic [7:0]     wdata_r;
  logic           found_r;
  logic [DIW-1:0] dev_r;
  logic [AW-1:0]  addr_r;
  logic [DIW-1:0] in_dev;
  logic [AW-1:0]  rd_addr;

  logic in_acc;
  logic finish;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign finish    = (state_r == ST_EXEC) && (!out_tvalid || out_tready);

  assign in_dev  = in_match.dev[DIW-1:0];
  assign rd_addr = AW'(in_dev) * AW'(REG_DEPTH) + AW'(index_r[in_dev]);

  // register memory, read data registered
  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata_r;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (in_acc) rdata_r <= mem[rd_addr];
  end

  // write-back datapath
  logic [2:0]     ph;
  logic [RIW-1:0] ptr;
  logic [RIW-1:0] ptr_inc;
  logic           wide;
  logic [2:0]     ph_nxt;
  logic [RIW-1:0] ptr_nxt;
  logic           ex_we;
  logic [15:0]    ex_wdata;
  logic [7:0]     rd_byte;

  assign ph      = phase_r[dev_r];
  assign ptr     = index_r[dev_r];
  assign ptr_inc = (ptr == RIW'(REG_DEPTH - 1)) ? '0 : ptr + 1'b1;
  assign wide    = wide_mask_r[3'(dev_r)];

  always_comb begin
    ph_nxt   = ph;
    ptr_nxt  = ptr;
    ex_we    = 1'b0;
    ex_wdata = rdata_r;
    rd_byte  = 8'd0;
    unique case (cmd_r)
      CMD_START: ph_nxt = PH_NEW;
      CMD_STOP: begin
        ph_nxt  = PH_IDLE;
        ptr_nxt = '0;
      end
      CMD_WRITE: begin
        priority if (ph == PH_NEW) begin
          ph_nxt  = PH_PTR;
          ptr_nxt = ModTab[wdata_r][RIW-1:0];
        end else if (ph == PH_PTR || ph == PH_RX_FULL) begin
          ex_we = 1'b1;
          if (wide) begin
            ph_nxt   = PH_RX_HALF;
            ex_wdata = {wdata_r, 8'd0};
          end else begin
            ph_nxt   = PH_RX_FULL;
            ex_wdata = {8'd0, wdata_r};
            ptr_nxt  = ptr_inc;
          end
        end else if (wide && ph == PH_RX_HALF) begin
          ex_we    = 1'b1;
          ph_nxt   = PH_RX_FULL;
          ex_wdata = rdata_r | {8'd0, wdata_r};
          ptr_nxt  = ptr_inc;
        end else begin
          // ignore writes in any other phase
        end
      end
      CMD_READ: begin
        priority if (ph == PH_PTR || ph == PH_TX_FULL) begin
          if (wide) begin
            ph_nxt  = PH_TX_HALF;
            rd_byte = rdata_r[15:8];
          end else begin
            ph_nxt  = PH_TX_FULL;
            ptr_nxt = ptr_inc;
            rd_byte = rdata_r[7:0];
          end
        end else if (wide && ph == PH_TX_HALF) begin
          ph_nxt  = PH_TX_FULL;
          ptr_nxt = ptr_inc;
          rd_byte = rdata_r[7:0];
        end else begin
          // reads in other phases return zero
        end
      end
      default: ;
    endcase
  end

  // clearing pass shares the write port
  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = 16'd0;
    end else begin
      mem_we    = finish && found_r && ex_we;
      mem_waddr = addr_r;
      mem_wdata = ex_wdata;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC:  if (finish) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  // capture the event on acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r   <= in_cmd;
      wdata_r <= in_wdata;
      found_r <= in_match.found;
      dev_r   <= in_dev;
      addr_r  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < USED; i++) begin
        phase_r[i] <= PH_IDLE;
        index_r[i] <= '0;
      end
    end else if (finish && found_r) begin
      phase_r[dev_r] <= ph_nxt;
      index_r[dev_r] <= ptr_nxt;
    end
  end

  // result register
  logic       out_valid_r;
  logic [7:0] out_rd_r;
  logic       out_found_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_rd_r    <= found_r ? rd_byte : 8'd0;
      out_found_r <= found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_found_r, out_rd_r};

endmodule

>>> test/i2ctrb_bank_checker.sv
// Checker for the I2C target register bank: tracks device state and compares each result.
module i2ctrb_bank_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // cmd[1:0], target_address[8:2], write_data[16:9]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,  // read_data[7:0], device_found[8]
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [55:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          n_events,
  output int          n_found,
  output int          n_data
);
  import i2ctrb_pkg::*;

  localparam int DEVS  = DEV_SLOTS_DEF;
  localparam int DEPTH = REG_DEPTH_DEF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       found;
  } bus_reply_t;

  logic [55:0] dev_addrs;
  logic [3:0]  dev_count;
  logic [7:0]  wide_mask;
  logic [2:0]  dev_phase [DEVS];
  logic [7:0]  dev_ptr [DEVS];
  logic [15:0] reg_file [DEVS*DEPTH];

  bus_reply_t expected_replies [$];

  function automatic logic [7:0] bump(input logic [7:0] p);
    return 8'((p + 1) % DEPTH);
  endfunction

  // Update the device model for one bus event and return the reply it produces.
  task automatic apply_bus_event(input logic [1:0] cmd, input logic [6:0] addr,
                                 input logic [7:0] data, output bus_reply_t reply);
    int         hit;
    int         live;
    int         slot;
    logic       wide;
    logic [2:0] ph;
    logic [7:0] p;
    live = dev_count;
    if (live > DEVS) live = DEVS;
    if (live > MAX_PACKED) live = MAX_PACKED;
    hit = -1;
    for (int i = 0; i < live; i++) begin
      if (hit < 0 && dev_addrs[7*i +: 7] == addr) hit = i;
    end
    reply.read_data = 8'h00;
    reply.found = (hit >= 0);
    if (hit >= 0) begin
      wide = wide_mask[hit];
      ph   = dev_phase[hit];
      p    = dev_ptr[hit];
      slot = hit * DEPTH + (p % DEPTH);
      case (cmd)
        CMD_START: dev_phase[hit] = PH_NEW;
        CMD_STOP: begin
          dev_phase[hit] = PH_IDLE;
          dev_ptr[hit]   = 8'h00;
        end
        CMD_WRITE: begin
          if (ph == PH_NEW) begin
            dev_phase[hit] = PH_PTR;
            dev_ptr[hit]   = 8'(data % DEPTH);
          end else if (ph == PH_PTR || ph == PH_RX_FULL) begin
            if (wide) begin
              dev_phase[hit] = PH_RX_HALF;
              reg_file[slot] = {data, 8'h00};
            end else begin
              dev_phase[hit] = PH_RX_FULL;
              reg_file[slot] = {8'h00, data};
              dev_ptr[hit]   = bump(p);
            end
          end else if (wide && ph == PH_RX_HALF) begin
            dev_phase[hit] = PH_RX_FULL;
            reg_file[slot] = reg_file[slot] | {8'h00, data};
            dev_ptr[hit]   = bump(p);
          end
        end
        CMD_READ: begin
          if (ph == PH_PTR || ph == PH_TX_FULL) begin
            if (wide) begin
              dev_phase[hit]  = PH_TX_HALF;
              reply.read_data = reg_file[slot][15:8];
            end else begin
              dev_phase[hit]  = PH_TX_FULL;
              dev_ptr[hit]    = bump(p);
              reply.read_data = reg_file[slot][7:0];
            end
          end else if (wide && ph == PH_TX_HALF) begin
            dev_phase[hit]  = PH_TX_FULL;
            dev_ptr[hit]    = bump(p);
            reply.read_data = reg_file[slot][7:0];
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    bus_reply_t got;
    bus_reply_t want;
    if (!rst_n) begin
      dev_addrs = DEV_ADDR_RST;
      dev_count = DEV_COUNT_RST;
      wide_mask = WIDE_MASK_RST;
      for (int i = 0; i < DEVS; i++) begin
        dev_phase[i] = PH_IDLE;
        dev_ptr[i]   = 8'h00;
      end
      for (int i = 0; i < DEVS*DEPTH; i++) reg_file[i] = 16'h0000;
      expected_replies.delete();
      fail_count = 0;
      n_events   = 0;
      n_found    = 0;
      n_data     = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_DEV_ADDR:  dev_addrs = cfg_data;
          CFG_DEV_COUNT: dev_count = cfg_data[3:0];
          CFG_WIDE_MASK: wide_mask = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.read_data = out_tdata[7:0];
        got.found     = out_tdata[8];
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected result read_data=%h found=%b", $time,
                   got.read_data, got.found);
          fail_count++;
        end else begin
          want = expected_replies.pop_front();
          if (got.read_data !== want.read_data) begin
            $display("%0t: read_data mismatch, expected %h got %h", $time,
                     want.read_data, got.read_data);
            fail_count++;
          end
          if (got.found !== want.found) begin
            $display("%0t: device_found mismatch, expected %b got %b", $time,
                     want.found, got.found);
            fail_count++;
          end
          n_events++;
          if (want.found) n_found++;
          if (want.read_data != 8'h00) n_data++;
        end
      end
      if (in_tvalid && in_tready) begin
        apply_bus_event(in_tdata[1:0], in_tdata[8:2], in_tdata[16:9], want);
        expected_replies.push_back(want);
      end
    end
    pending = expected_replies.size();
  end

endmodule

>>> test/tb_top.sv
// Top-level testbench for the I2C target register bank: stimulus, settings and verdict.
module tb_top;
  import i2ctrb_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // cmd[1:0], target_address[8:2], write_data[16:9]
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // read_data[7:0], device_found[8]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [55:0] cfg_data;

  int fail_count;
  int pending;
  int n_events;
  int n_found;
  int n_data;

  int          send_idle = 13;
  int          recv_idle = 59;
  int unsigned events_sent = 0;
  int          quiet_cycles = 0;
  logic [55:0] cur_addrs = DEV_ADDR_RST;
  logic [3:0]  cur_count = DEV_COUNT_RST;

  i2c_target_register_bank u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  i2ctrb_bank_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .n_events   (n_events),
    .n_found    (n_found),
    .n_data     (n_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  // End the run if no transaction of any kind completes for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [6:0] dev_address(input int i);
    return cur_addrs[7*i +: 7];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_item(input logic [1:0] cmd, input logic [6:0] addr,
                           input logic [7:0] data);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, data, addr, cmd};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    events_sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [55:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Drain all results, then reprogram the bank while it is idle.
  task automatic set_registers(input logic [55:0] addrs, input logic [3:0] count,
                               input logic [7:0] wide);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_reg(CFG_DEV_ADDR, addrs);
    write_reg(CFG_DEV_COUNT, 56'(count));
    write_reg(CFG_WIDE_MASK, 56'(wide));
    cfg_valid <= 1'b0;
    cur_addrs = addrs;
    cur_count = count;
  endtask

  // Reset settings: device 0 is narrow, device 1 is wide, six devices enabled.
  task automatic directed_events();
    logic [6:0] a0;
    logic [6:0] a1;
    a0 = dev_address(0);
    a1 = dev_address(1);
    send_item(CMD_READ, a0, 8'h00);    // read while idle
    send_item(CMD_WRITE, a0, 8'hFF);   // write while idle is dropped
    send_item(CMD_START, a0, 8'h00);
    send_item(CMD_WRITE, a0, 8'hFF);   // pointer wraps to the last register
    send_item(CMD_WRITE, a0, 8'hFF);
    send_item(CMD_WRITE, a0, 8'h00);   // pointer wrapped to register 0
    send_item(CMD_START, a0, 8'hFF);
    send_item(CMD_WRITE, a0, 8'h0F);
    send_item(CMD_READ, a0, 8'h00);
    send_item(CMD_READ, a0, 8'h00);
    send_item(CMD_STOP, a0, 8'h00);
    send_item(CMD_START, a1, 8'h00);
    send_item(CMD_WRITE, a1, 8'h03);
    send_item(CMD_WRITE, a1, 8'hFF);   // high byte first
    send_item(CMD_WRITE, a1, 8'h80);
    send_item(CMD_START, a1, 8'h00);
    send_item(CMD_WRITE, a1, 8'h03);
    send_item(CMD_READ, a1, 8'h00);
    send_item(CMD_READ, a1, 8'h00);
    send_item(CMD_READ, a1, 8'h00);
    send_item(CMD_STOP, a1, 8'hFF);
    send_item(CMD_READ, 7'h00, 8'h00);
    send_item(CMD_READ, 7'h7F, 8'hFF);
    send_item(CMD_START, dev_address(6), 8'h00);  // beyond the enabled count
    send_item(CMD_READ, dev_address(7), 8'h00);
  endtask

  // Mostly well-formed bus transactions with random content, plus stray events.
  task automatic run_traffic(input int unsigned items);
    int unsigned stop_at;
    int          live;
    int          kind;
    int          k;
    logic [6:0]  tgt;
    stop_at = events_sent + items;
    while (events_sent < stop_at) begin
      live = (cur_count > 8) ? 8 : cur_count;
      if ($urandom_range(99) < 12) begin
        send_item(2'($urandom_range(3)), 7'($urandom_range(127)), 8'($urandom));
      end else begin
        if ($urandom_range(99) < 5) tgt = 7'($urandom_range(127));
        else if (live == 0 || $urandom_range(99) < 12) tgt = dev_address($urandom_range(7));
        else tgt = dev_address($urandom_range(live - 1));
        kind = $urandom_range(3);
        k    = $urandom_range(6);
        send_item(CMD_START, tgt, 8'($urandom));
        send_item(CMD_WRITE, tgt, 8'($urandom));
        case (kind)
          0: repeat (k) send_item(CMD_WRITE, tgt, 8'($urandom));
          1: begin
            send_item(CMD_START, tgt, 8'($urandom));
            repeat (k + 1) send_item(CMD_READ, tgt, 8'($urandom));
          end
          2: repeat (k + 1) send_item(CMD_READ, tgt, 8'($urandom));
          default: repeat (k + 1) send_item(2'($urandom_range(3)), tgt, 8'($urandom));
        endcase
        if ($urandom_range(99) < 85) send_item(CMD_STOP, tgt, 8'($urandom));
      end
    end
  endtask

  initial begin
    logic [55:0] dup;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_DEV_ADDR;
    cfg_data   = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    directed_events();
    set_registers(56'({$urandom, $urandom}), 4'd8, 8'hA5);
    run_traffic(350);
    dup = 56'({$urandom, $urandom});
    dup[21 +: 7] = dup[6:0];
    dup[35 +: 7] = dup[6:0];
    set_registers(dup, 4'd15, 8'hFF);
    run_traffic(300);

    send_idle = 59;
    recv_idle = 13;
    set_registers(56'h0, 4'd4, 8'h00);
    run_traffic(100);
    set_registers(56'({$urandom, $urandom}), 4'd3, 8'($urandom));
    run_traffic(350);
    set_registers({56{1'b1}}, 4'd8, 8'h01);
    run_traffic(100);

    send_idle = 0;
    recv_idle = 0;
    set_registers(56'({$urandom, $urandom}), 4'd0, 8'($urandom));
    run_traffic(50);
    set_registers(56'({$urandom, $urandom}), 4'd8, 8'($urandom));
    run_traffic(700);

    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    $display("Checked %0d bus events over eight register settings and three idle patterns;",
             n_events);
    $display("%0d addressed an enabled device and %0d returned nonzero read data.",
             n_found, n_data);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
